// ===== hw/rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants
// widths, memory geometry and command codes for the bitmask tour solver
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int MaxCities = 12;
  localparam int CityW     = 4;
  localparam int CostW     = 16;
  localparam int TotW      = 20;
  localparam int PosW      = 4;
  localparam int SetCount  = 1 << MaxCities;
  localparam int MemoDepth = MaxCities * SetCount;
  localparam int MemoAw    = $clog2(MemoDepth);
  localparam int EdgeDepth = MaxCities * MaxCities;
  localparam int EdgeAw    = $clog2(EdgeDepth);

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdSolve = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [CityW-1:0]   from_city;
    logic [CityW-1:0]   to_city;
    logic [CostW-1:0]   edge_cost;
  } in_word_t;

  typedef struct packed {
    logic [TotW-1:0]    tour_cost;
    logic [CityW-1:0]   tour_city;
    logic [PosW-1:0]    tour_position;
    logic               last;
  } out_word_t;

  // one memo entry: remaining cost and best next city
  typedef struct packed {
    logic [TotW-1:0]  cost;
    logic [CityW-1:0] next;
  } memo_t;

  function automatic logic [MemoAw-1:0] memo_addr(logic [CityW-1:0] v,
                                                  logic [MaxCities-1:0] m);
    logic [MemoAw-1:0] r;
    r = MemoAw'(v) * MemoAw'(SetCount) + MemoAw'(m);
    return r;
  endfunction

  function automatic logic [EdgeAw-1:0] edge_addr(logic [CityW-1:0] a,
                                                 logic [CityW-1:0] b);
    logic [EdgeAw-1:0] r;
    r = EdgeAw'(a) * EdgeAw'(MaxCities) + EdgeAw'(b);
    return r;
  endfunction

endpackage

// ===== hw/rtl/tsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_if: valid/ready channel
// carries one word of a given packed type between a source and a sink
// ----------------------------------------------------------------------------
interface tsp_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tsp_bitmask_dp_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_bitmask_dp_solver: held-karp asymmetric tour solver
// edge loads, memo fill over descending visited sets, then a tour walk
// ----------------------------------------------------------------------------
// A load word writes one edge cost and loads may follow back to back. A
// solve word blocks input while the memo is filled: for each odd set from
// the full set down and each city v in it, every city i outside the set is
// tried, one candidate per cycle through a two stage read (edge and memo
// reads issued together, summed and compared next cycle). A city in the set
// passes through entry, n candidate slots and write (entry and write only
// for the full set), and a city outside it through entry alone. A memo
// entry is written only after all its candidates were read, and those read
// entries belong to strictly larger sets, written earlier, so no read/write
// overlap exists. The walk then reads the next city from the memo and
// emits n + 1 words; the output register lets the walk advance while a
// word waits.
module tsp_bitmask_dp_solver import tsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CityW-1:0] cfg_wdata_i,
  tsp_if.sink              in_if,
  tsp_if.source            out_if
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StEntry = 8'b0000_0010, // start work on (mask, v)
    StCand  = 8'b0000_0100, // issue reads for candidate i
    StWrite = 8'b0000_1000, // drain last candidate, write memo
    StTot   = 8'b0001_0000, // read memo of city 0 with set {0}
    StWalk  = 8'b0010_0000, // read next city
    StEmit  = 8'b0100_0000, // place a word in the output register
    StDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CityW-1:0] cnt_q;
  logic [CityW-1:0] n_w;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CityW'(4);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end
  // clamp to the supported range
  always_comb begin
    if (cnt_q < CityW'(2)) begin
      n_w = CityW'(2);
    end else if (cnt_q > CityW'(MaxCities)) begin
      n_w = CityW'(MaxCities);
    end else begin
      n_w = cnt_q;
    end
  end

  logic [MaxCities-1:0] full_w;
  assign full_w = MaxCities'((1 << n_w) - 1);

  // sequencer registers
  logic [MaxCities-1:0] mask_q, mask_d;
  logic [CityW-1:0]     v_q, v_d, i_q, i_d, pick_q, pick_d;
  logic [TotW-1:0]      best_q, best_d, total_q, total_d;
  logic                 best_ok_q, best_ok_d;   // best holds a real candidate
  logic                 pend_q, pend_d;         // a candidate read is in flight
  logic [CityW-1:0]     pend_i_q, pend_i_d;
  logic [CityW-1:0]     cur_q, cur_d;
  logic [PosW-1:0]      pos_q, pos_d;

  // output register
  out_word_t ow_q, ow_d;
  logic      ov_q, ov_d;

  // memories
  logic              e_we, m_we;
  logic [EdgeAw-1:0] e_waddr, e_raddr;
  logic [CostW-1:0]  e_rdata;
  logic [MemoAw-1:0] m_waddr, m_raddr;
  memo_t             m_wdata, m_rdata;

  in_word_t iw;
  assign iw = in_if.data;

  assign in_if.ready = (state_q == StIdle);
  logic acc;
  assign acc = in_if.valid && in_if.ready;

  assign e_we    = acc && (iw.cmd == CmdLoad) && (iw.from_city < CityW'(MaxCities))
                   && (iw.to_city < CityW'(MaxCities));
  assign e_waddr = edge_addr(iw.from_city, iw.to_city);

  tsp_edge_ram u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(iw.edge_cost),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  tsp_memo_ram u_memo (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  // candidate sum from the reads issued in the previous cycle
  logic [TotW-1:0] cand_w;
  assign cand_w = TotW'(e_rdata) + m_rdata.cost;

  logic out_free;
  assign out_free = !ov_q || out_if.ready;

  always_comb begin
    state_d   = state_q;
    mask_d    = mask_q;
    v_d       = v_q;
    i_d       = i_q;
    pick_d    = pick_q;
    best_d    = best_q;
    best_ok_d = best_ok_q;
    pend_d    = 1'b0;
    pend_i_d  = i_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    total_d   = total_q;
    ow_d      = ow_q;
    ov_d      = ov_q && !out_if.ready;
    e_raddr   = edge_addr(v_q, i_q);
    m_raddr   = memo_addr(i_q, mask_q | MaxCities'(1 << i_q));
    m_we      = 1'b0;
    m_waddr   = memo_addr(v_q, mask_q);
    m_wdata   = '{cost: best_q, next: pick_q};

    // fold in the candidate read last cycle
    if (pend_q && (!best_ok_q || cand_w < best_q)) begin
      best_d    = cand_w;
      pick_d    = pend_i_q;
      best_ok_d = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (acc && iw.cmd == CmdSolve) begin
          mask_d  = full_w;
          v_d     = '0;
          state_d = StEntry;
        end
      end
      StEntry: begin
        best_ok_d = 1'b0;
        best_d    = '0;
        pick_d    = '0;
        i_d       = '0;
        if (!mask_q[v_q]) begin
          // city outside the set: skip
          if (v_q == n_w - CityW'(1)) begin
            if (mask_q == MaxCities'(1)) begin
              state_d = StTot;
            end else begin
              mask_d = mask_q - MaxCities'(2);
              v_d    = '0;
            end
          end else begin
            v_d = v_q + CityW'(1);
          end
        end else if (mask_q == full_w) begin
          // final hop back to city 0
          e_raddr = edge_addr(v_q, '0);
          state_d = StWrite;
        end else begin
          state_d = StCand;
        end
      end
      StCand: begin
        if (!mask_q[i_q]) begin
          pend_d = 1'b1;
        end
        if (i_q == n_w - CityW'(1)) begin
          state_d = StWrite;
        end else begin
          i_d = i_q + CityW'(1);
        end
      end
      StWrite: begin
        m_we = 1'b1;
        if (mask_q == full_w) begin
          m_wdata = '{cost: TotW'(e_rdata), next: '0};
        end else begin
          m_wdata = '{cost: best_d, next: pick_d};
        end
        state_d = StEntry;
        if (v_q == n_w - CityW'(1)) begin
          if (mask_q == MaxCities'(1)) begin
            state_d = StTot;
          end else begin
            mask_d = mask_q - MaxCities'(2);
            v_d    = '0;
          end
        end else begin
          v_d = v_q + CityW'(1);
        end
      end
      StTot: begin
        m_raddr = memo_addr('0, MaxCities'(1));
        cur_d   = '0;
        pos_d   = '0;
        mask_d  = MaxCities'(1);
        state_d = StWalk;
      end
      StWalk: begin
        if (pos_q == '0) begin
          total_d = m_rdata.cost;
        end
        state_d = StEmit;
      end
      StEmit: begin
        m_raddr = memo_addr(cur_q, mask_q);
        if (out_free) begin
          ov_d = 1'b1;
          ow_d = '{tour_cost: (pos_q == '0) ? total_d : total_q,
                   tour_city: cur_q, tour_position: pos_q, last: 1'b0};
          if (pos_q == PosW'(n_w)) begin
            ow_d.tour_city = '0;
            ow_d.last      = 1'b1;
            state_d        = StDone;
          end else begin
            pos_d   = pos_q + PosW'(1);
            state_d = StWalk;
          end
        end else begin
          state_d = StEmit;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // take the next city when stepping the walk
    if (state_q == StWalk && pos_q != '0) begin
      if (pos_q == PosW'(n_w)) begin
        cur_d = '0;
      end else begin
        cur_d  = (m_rdata.next >= n_w) ? '0 : m_rdata.next;
        mask_d = mask_q | MaxCities'(1 << cur_d);
      end
      m_raddr = memo_addr(cur_d, mask_q);
    end
  end

  // walk read address: memo[cur][mask] must be valid when StWalk is left
  // for the next position, so StEmit re-issues the read above each cycle

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ov_q      <= 1'b0;
      pend_q    <= 1'b0;
      best_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ov_q      <= ov_d;
      pend_q    <= pend_d;
      best_ok_q <= best_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q   <= mask_d;
    v_q      <= v_d;
    i_q      <= i_d;
    pick_q   <= pick_d;
    best_q   <= best_d;
    pend_i_q <= pend_i_d;
    cur_q    <= cur_d;
    pos_q    <= pos_d;
    total_q  <= total_d;
    ow_q     <= ow_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = ow_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready) else $error("input taken while busy");
  a_memo_write_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_we |-> (state_q == StWrite)) else $error("memo write outside fill");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && ow_q.last) |-> (state_q == StDone ||
      state_q == StIdle)) else $error("last word before walk end");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> (ov_q && $stable(ow_q)))
    else $error("output word changed while stalled");
`endif

endmodule

// ===== hw/rtl/tsp_memo_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_memo_ram: memo store
// one write port and one registered read port over all city/set entries
// ----------------------------------------------------------------------------
module tsp_memo_ram import tsp_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [MemoAw-1:0] waddr_i,
  input  memo_t             wdata_i,
  input  logic [MemoAw-1:0] raddr_i,
  output memo_t             rdata_o
);
  memo_t mem [MemoDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hw/rtl/tsp_edge_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_edge_ram: edge cost matrix
// one write port and one registered read port
// ----------------------------------------------------------------------------
module tsp_edge_ram import tsp_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [EdgeAw-1:0] waddr_i,
  input  logic [CostW-1:0]  wdata_i,
  input  logic [EdgeAw-1:0] raddr_i,
  output logic [CostW-1:0]  rdata_o
);
  logic [CostW-1:0] mem [EdgeDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== tb/sv/tb_tsp_bitmask_dp_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tsp_bitmask_dp_solver: self-checking bench for the bitmask tour solver
// edge loads and solves are driven through bursty valid/ready traffic with a
// stalling receiver; a local held-karp predictor forms the expected tour words
// and a monitor compares every output word field by field
// ----------------------------------------------------------------------------
module tb_tsp_bitmask_dp_solver;
  import tsp_pkg::*;

  localparam int CycleLimit = 4_000_000;
  localparam int IdlePause  = 20;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CityW-1:0] cfg_wdata_i;

  tsp_if #(.word_t(in_word_t))  in_ch ();
  tsp_if #(.word_t(out_word_t)) out_ch ();

  tsp_bitmask_dp_solver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // stimulus side: pending words and what the generator has loaded so far
  in_word_t    pending_words[$];
  int unsigned words_pushed;
  int unsigned words_taken;
  bit          edge_loaded[MaxCities][MaxCities];

  // predictor side: own copy of the edge matrix, memo tables and city count
  logic [CostW-1:0] edge_cost_mem[MaxCities][MaxCities];
  int unsigned      rem_cost[MaxCities * SetCount];
  int unsigned      next_hop[MaxCities * SetCount];
  logic [CityW-1:0] city_count_reg;
  out_word_t        expected_tour[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // clock, free running from time zero
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // held-karp fill for the current city count, then the walk from city 0;
  // every tour word is queued as an expectation
  function automatic void predict_tour();
    int unsigned n, full, best, pick, cand, at, total, cur, msk, nxt;
    int m;
    out_word_t w;
    n = city_count_reg;
    if (n < 2) n = 2;
    if (n > MaxCities) n = MaxCities;
    full = (1 << n) - 1;
    // descending sets so every successor set is already filled
    for (m = full; m >= 1; m--) begin
      if (m[0] == 1'b0) continue;
      for (int v = 0; v < n; v++) begin
        if (((m >> v) & 1) == 0) continue;
        at = v * SetCount + m;
        if (m == full) begin
          rem_cost[at] = edge_cost_mem[v][0];
          next_hop[at] = 0;
          continue;
        end
        best = 32'hFFFF_FFFF;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          if (((m >> i) & 1) != 0) continue;
          cand = edge_cost_mem[v][i] + rem_cost[i * SetCount + (m | (1 << i))];
          // strict compare keeps the lowest index on a tie
          if (cand < best) begin
            best = cand;
            pick = i;
          end
        end
        rem_cost[at] = best;
        next_hop[at] = pick;
      end
    end
    total = rem_cost[1] & 32'hF_FFFF;
    cur = 0;
    msk = 1;
    for (int pos = 0; pos < n; pos++) begin
      w.tour_cost     = TotW'(total);
      w.tour_city     = CityW'(cur);
      w.tour_position = PosW'(pos);
      w.last          = 1'b0;
      expected_tour.push_back(w);
      if (pos + 1 < n) begin
        nxt = next_hop[cur * SetCount + msk];
        if (nxt >= n) nxt = 0;
        msk = msk | (1 << nxt);
        cur = nxt;
      end
    end
    w.tour_cost     = TotW'(total);
    w.tour_city     = '0;
    w.tour_position = PosW'(n);
    w.last          = 1'b1;
    expected_tour.push_back(w);
  endfunction

  // ---------------------------------------------------------------- driver
  // bursts of back to back words separated by random gaps; valid is held
  // until the word is taken
  bit word_taken;
  int burst_left;
  int gap_left;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    word_taken  = 1'b0;
    burst_left  = 8;
    gap_left    = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || word_taken)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        in_ch.data  <= pending_words.pop_front();
        in_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          // a third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------- receiver
  // stall pattern of its own: always ready, coin flip, or one in four
  int stall_mode;
  int stall_phase;
  int mode_left;

  always @(negedge clk_i) begin
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(5, 60);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (stall_phase % 4 == 0);
    endcase
  end

  // -------------------------------------------- accepted inputs, predictor
  always @(posedge clk_i) begin
    word_taken <= in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      words_taken++;
      if (in_ch.data.cmd == CmdLoad) begin
        // out of range cities leave the matrix alone
        if (in_ch.data.from_city < MaxCities && in_ch.data.to_city < MaxCities)
          edge_cost_mem[in_ch.data.from_city][in_ch.data.to_city] = in_ch.data.edge_cost;
      end else begin
        predict_tour();
      end
    end
  end

  // ------------------------------------------------------ output checking
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_tour.size() == 0) begin
        report_mismatch("tour word with nothing expected");
      end else begin
        want = expected_tour.pop_front();
        if (out_ch.data.tour_cost !== want.tour_cost)
          report_mismatch($sformatf("tour_cost %0d want %0d",
                                    out_ch.data.tour_cost, want.tour_cost));
        if (out_ch.data.tour_city !== want.tour_city)
          report_mismatch($sformatf("tour_city %0d want %0d",
                                    out_ch.data.tour_city, want.tour_city));
        if (out_ch.data.tour_position !== want.tour_position)
          report_mismatch($sformatf("tour_position %0d want %0d",
                                    out_ch.data.tour_position, want.tour_position));
        if (out_ch.data.last !== want.last)
          report_mismatch($sformatf("last %0b want %0b", out_ch.data.last, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------ stimulus
  function automatic void push_word(input logic cmd, input int from_c, input int to_c,
                                    input int cost);
    in_word_t w;
    w.cmd       = cmd;
    w.from_city = CityW'(from_c);
    w.to_city   = CityW'(to_c);
    w.edge_cost = CostW'(cost);
    pending_words.push_back(w);
    words_pushed++;
    if (cmd == CmdLoad && from_c < MaxCities && to_c < MaxCities)
      edge_loaded[from_c][to_c] = 1'b1;
  endfunction

  // costs lean on the extremes and on tiny values so ties show up
  function automatic int pick_cost();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 3);
      3: return $urandom_range(65000, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic wait_idle();
    while (!(words_taken == words_pushed && expected_tour.size() == 0))
      @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic write_city_count(input int value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CityW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    city_count_reg = CityW'(value);
  endtask

  // reloads a few pairs, fills any gap so the solve never reads an unloaded
  // edge, sprinkles ignored loads, then solves
  task automatic solve_round(input int n);
    int reloads;
    reloads = $urandom_range(1, 6);
    for (int k = 0; k < reloads; k++)
      push_word(CmdLoad, $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_cost());
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (!edge_loaded[a][b]) push_word(CmdLoad, a, b, pick_cost());
    if ($urandom_range(0, 2) == 0)
      push_word(CmdLoad, $urandom_range(MaxCities, 15), $urandom_range(0, 15), pick_cost());
    if ($urandom_range(0, 2) == 0)
      push_word(CmdLoad, $urandom_range(0, 15), $urandom_range(MaxCities, 15), pick_cost());
    push_word(CmdSolve, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 65535));
  endtask

  int phase_counts[] = '{2, 0, 3, 1, 5, 6, 12, 7, 3, 8, 15, 4, 2, 9, 5, 3};

  initial begin
    int n;
    rst_ni = 1'b0;
    city_count_reg = 4'd4;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset city count of four, extreme costs, ignored loads
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++)
        push_word(CmdLoad, a, b, ((a + b) % 2 == 0) ? 65535 : 0);
    push_word(CmdLoad, 15, 0, 1);
    push_word(CmdLoad, 0, 12, 2);
    push_word(CmdLoad, 11, 15, 65535);
    push_word(CmdSolve, 0, 0, 0);
    push_word(CmdLoad, 1, 2, 1);
    push_word(CmdSolve, 15, 15, 65535);

    // random phases over several city counts, the clamped ones included
    foreach (phase_counts[p]) begin
      write_city_count(phase_counts[p]);
      n = phase_counts[p];
      if (n < 2) n = 2;
      if (n > MaxCities) n = MaxCities;
      if (n >= 10) begin
        solve_round(n);
      end else begin
        repeat ($urandom_range(1, 2)) solve_round(n);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_if.sv
hw/rtl/tsp_memo_ram.sv
hw/rtl/tsp_edge_ram.sv
hw/rtl/tsp_bitmask_dp_solver.sv
tb/sv/tb_tsp_bitmask_dp_solver.sv
